// ===== design/sorted_interval_set_core_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef SORTED_INTERVAL_SET_CORE_MACROS_SVH
`define SORTED_INTERVAL_SET_CORE_MACROS_SVH

// Same-cycle implication.
`define SIS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SIS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sis_pkg.sv =====
package sis_pkg;

   localparam int FIELD_BITS = 16;
   localparam int COUNT_FIELD_BITS = 6;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_SUB   = 2'd1;
   localparam logic [1:0] OP_PROBE = 2'd2;
   // unassigned code, handled as a probe
   localparam logic [1:0] OP_OTHER = 2'd3;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [FIELD_BITS-1:0] seg_start;
      logic [FIELD_BITS-1:0] seg_end;
   } sis_req_type;

   typedef struct packed {
      logic                        hit;
      logic                        overflow;
      logic                        bad_segment;
      logic                        set_empty;
      logic [FIELD_BITS-1:0]       cover_start;
      logic [FIELD_BITS-1:0]       cover_end;
      logic [COUNT_FIELD_BITS-1:0] entry_count;
   } sis_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_DONE
   } sis_state_type;

endpackage

// ===== design/sis_stream_if.sv =====
interface sis_stream_if #(parameter type data_type = logic);
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== design/sorted_interval_set_core.sv =====
// Flow: a bad segment goes from IDLE straight to DONE, which loads its result; any
// other request makes a linear pass over the stored entries, drains the read pipe,
// flushes any pending pieces in FLUSH and then loads the result in DONE.
// Throughput: one request at a time; a new request is taken only once the result is
// loaded, and a result still waiting on rsp ready holds the next one back in DONE.
// Reset: synchronous; the set comes up empty, memory contents are not cleared.
module sorted_interval_set_core #(
   parameter int MAX_SEGMENTS = 32,
   parameter int OFFSET_BITS  = 16
) (
   input logic               clock,
   input logic               reset,
   sis_stream_if.sink        req_if,
   sis_stream_if.source      rsp_if
);

   localparam int OW    = OFFSET_BITS;
   localparam int EW    = 2 * OFFSET_BITS;
   localparam int IW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW    = $clog2(MAX_SEGMENTS + 2);
   localparam int DEPTH = 2 * (2 ** IW);

   // Two banks: pass reads the live bank and writes the result into the other.
   logic [EW-1:0] seg_mem_ff [DEPTH];
   logic [EW-1:0] mem_q_ff;

   sis_pkg::sis_state_type state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [OW-1:0] s_ff, s_in, e_ff, e_in, ms_ff, ms_in, me_ff, me_in;
   logic          placed_ff, placed_in, hit_ff, hit_in, bad_ff, bad_in;
   logic          bank_ff, bank_in, dv_ff, dv_in, buf_v_ff, buf_v_in;
   logic [CW-1:0] count_ff, count_in, rd_ptr_ff, rd_ptr_in, wr_cnt_ff, wr_cnt_in;
   logic [EW-1:0] buf_ff, buf_in;
   logic [OW-1:0] first_ff, first_in, last_ff, last_in;
   logic [OW-1:0] cov_s_ff, cov_s_in, cov_e_ff, cov_e_in;
   logic          rsp_v_ff, rsp_v_in;
   sis_pkg::sis_rsp_type rsp_ff, rsp_in;

   logic          rd_en, wr_en, mem_wr;
   logic [EW-1:0] wr_data;
   logic          e0_v, e1_v;
   logic [EW-1:0] e0, e1;
   logic [OW-1:0] a, b, in_s, in_e;
   logic          is_add, is_sub, modify, ovf;

   assign a    = mem_q_ff[EW-1:OW];
   assign b    = mem_q_ff[OW-1:0];
   assign in_s = OW'(32'(req_if.data.seg_start));
   assign in_e = OW'(32'(req_if.data.seg_end));
   assign is_add = (op_ff == sis_pkg::OP_ADD);
   assign is_sub = (op_ff == sis_pkg::OP_SUB);
   assign modify = (is_add || is_sub) && !bad_ff;
   assign ovf    = modify && (wr_cnt_ff > CW'(MAX_SEGMENTS));
   assign mem_wr = wr_en && (wr_cnt_ff < CW'(MAX_SEGMENTS));

   assign req_if.ready = (state_ff == sis_pkg::ST_IDLE);
   assign rsp_if.valid = rsp_v_ff;
   assign rsp_if.data  = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      s_in      = s_ff;
      e_in      = e_ff;
      ms_in     = ms_ff;
      me_in     = me_ff;
      placed_in = placed_ff;
      hit_in    = hit_ff;
      bad_in    = bad_ff;
      bank_in   = bank_ff;
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_cnt_in = wr_cnt_ff;
      buf_v_in  = buf_v_ff;
      buf_in    = buf_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      cov_s_in  = cov_s_ff;
      cov_e_in  = cov_e_ff;
      rsp_in    = rsp_ff;
      rsp_v_in  = rsp_v_ff && !rsp_if.ready;
      dv_in     = 1'b0;
      rd_en     = 1'b0;
      e0_v      = 1'b0;
      e1_v      = 1'b0;
      e0        = mem_q_ff;
      e1        = mem_q_ff;
      wr_en     = 1'b0;
      wr_data   = buf_ff;

      case (state_ff)
         sis_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               op_in     = req_if.data.req_type;
               s_in      = in_s;
               e_in      = in_e;
               ms_in     = in_s;
               me_in     = in_e;
               bad_in    = !(in_s < in_e);
               hit_in    = 1'b0;
               placed_in = 1'b0;
               rd_ptr_in = '0;
               wr_cnt_in = '0;
               buf_v_in  = 1'b0;
               state_in  = (in_s < in_e) ? sis_pkg::ST_SCAN : sis_pkg::ST_DONE;
            end
         end
         sis_pkg::ST_SCAN: begin
            if (rd_ptr_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            dv_in = rd_en;
            if (dv_ff) begin
               if (a < e_ff && b > s_ff)
                  hit_in = 1'b1;
               if (is_add) begin
                  if (placed_ff || b < ms_ff) begin
                     e0_v = 1'b1;
                  end else if (a <= me_ff) begin
                     if (a < ms_ff)
                        ms_in = a;
                     if (b > me_ff)
                        me_in = b;
                  end else begin
                     // merged segment goes out ahead of this entry
                     e0_v      = 1'b1;
                     e0        = {ms_ff, me_ff};
                     e1_v      = 1'b1;
                     placed_in = 1'b1;
                  end
               end else if (is_sub) begin
                  if (b <= s_ff || a >= e_ff) begin
                     e0_v = 1'b1;
                  end else begin
                     if (a < s_ff) begin
                        e0_v = 1'b1;
                        e0   = {a, s_ff};
                        if (b > e_ff) begin
                           e1_v = 1'b1;
                           e1   = {e_ff, b};
                        end
                     end else if (b > e_ff) begin
                        e0_v = 1'b1;
                        e0   = {e_ff, b};
                     end
                  end
               end
            end
            if (rd_ptr_ff == count_ff && !dv_ff)
               state_in = sis_pkg::ST_FLUSH;
         end
         sis_pkg::ST_FLUSH: begin
            if (is_add && !placed_ff) begin
               e0_v      = 1'b1;
               e0        = {ms_ff, me_ff};
               placed_in = 1'b1;
            end
            if (!buf_v_ff && !e0_v)
               state_in = sis_pkg::ST_DONE;
         end
         sis_pkg::ST_DONE: begin
            if (!rsp_v_ff || rsp_if.ready) begin
               if (modify && !ovf) begin
                  count_in = wr_cnt_ff;
                  bank_in  = !bank_ff;
                  cov_s_in = (wr_cnt_ff == '0) ? '0 : first_ff;
                  cov_e_in = (wr_cnt_ff == '0) ? '0 : last_ff;
               end
               rsp_in.hit         = hit_ff;
               rsp_in.overflow    = ovf;
               rsp_in.bad_segment = bad_ff;
               rsp_in.set_empty   = (count_in == '0);
               rsp_in.cover_start = sis_pkg::FIELD_BITS'(32'(cov_s_in));
               rsp_in.cover_end   = sis_pkg::FIELD_BITS'(32'(cov_e_in));
               rsp_in.entry_count = sis_pkg::COUNT_FIELD_BITS'(32'(count_in));
               rsp_v_in           = 1'b1;
               state_in           = sis_pkg::ST_IDLE;
            end
         end
         default: state_in = sis_pkg::ST_IDLE;
      endcase

      // one write per cycle; a second piece waits in the holding register
      if (buf_v_ff) begin
         wr_en    = 1'b1;
         wr_data  = buf_ff;
         buf_v_in = e0_v;
         buf_in   = e0;
      end else if (e0_v) begin
         wr_en    = 1'b1;
         wr_data  = e0;
         buf_v_in = e1_v;
         buf_in   = e1;
      end
      if (wr_en) begin
         wr_cnt_in = wr_cnt_ff + 1'b1;
         last_in   = wr_data[OW-1:0];
         if (wr_cnt_ff == '0)
            first_in = wr_data[EW-1:OW];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en)
         mem_q_ff <= seg_mem_ff[{bank_ff, rd_ptr_ff[IW-1:0]}];
      if (mem_wr)
         seg_mem_ff[{!bank_ff, wr_cnt_ff[IW-1:0]}] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sis_pkg::ST_IDLE;
         bank_ff  <= 1'b0;
         count_ff <= '0;
         cov_s_ff <= '0;
         cov_e_ff <= '0;
         rsp_v_ff <= 1'b0;
         dv_ff    <= 1'b0;
         buf_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
         count_ff <= count_in;
         cov_s_ff <= cov_s_in;
         cov_e_ff <= cov_e_in;
         rsp_v_ff <= rsp_v_in;
         dv_ff    <= dv_in;
         buf_v_ff <= buf_v_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      s_ff      <= s_in;
      e_ff      <= e_in;
      ms_ff     <= ms_in;
      me_ff     <= me_in;
      placed_ff <= placed_in;
      hit_ff    <= hit_in;
      bad_ff    <= bad_in;
      rd_ptr_ff <= rd_ptr_in;
      wr_cnt_ff <= wr_cnt_in;
      buf_ff    <= buf_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      rsp_ff    <= rsp_in;
   end

endmodule

// ===== design/sis_checker.sv =====
`include "sorted_interval_set_core_macros.svh"

module sis_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input sis_pkg::sis_rsp_type rsp_data
);

   `SIS_ASSERT_NOW(a_bad_quiet, clock, reset, rsp_valid && rsp_data.bad_segment, !rsp_data.hit && !rsp_data.overflow, "bad segment reported hit or overflow")
   `SIS_ASSERT_NOW(a_empty_count, clock, reset, rsp_valid, rsp_data.set_empty == (rsp_data.entry_count == '0), "empty flag disagrees with count")
   `SIS_ASSERT_NOW(a_empty_cover, clock, reset, rsp_valid && rsp_data.set_empty, rsp_data.cover_start == '0 && rsp_data.cover_end == '0, "empty set with nonzero cover")
   `SIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind sorted_interval_set_core sis_checker u_sis_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);
